>>> sv/idhc_pkg.sv
package idhc_pkg;

  // Field widths fixed by the CPU's programming model.
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned REQ_W   = 5;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned CYC_W   = 5;
  localparam int unsigned DELAY_W = 2;
  localparam int unsigned SRC_W   = 3;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_STEP    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HALT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ENABLE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DISABLE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BUG     = 3'd4;

  // Result actions.
  localparam logic [ACT_W-1:0] ACT_HALT_WAIT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HALT_WAKE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DISPATCH  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FETCH     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CONTROL   = 3'd4;

  // Step costs, as carried in the cycle_cost field of a result.
  localparam logic [CYC_W-1:0] CYC_DISPATCH  = 5'd20;
  localparam logic [CYC_W-1:0] CYC_HALT_WAIT = 5'd4;
  localparam logic [CYC_W-1:0] CYC_NONE      = 5'd0;

  // Interrupt vectors, one per source.
  localparam logic [ADDR_W-1:0] VEC_VBLANK = 16'h0040;
  localparam logic [ADDR_W-1:0] VEC_STAT   = 16'h0048;
  localparam logic [ADDR_W-1:0] VEC_TIMER  = 16'h0050;
  localparam logic [ADDR_W-1:0] VEC_SERIAL = 16'h0058;
  localparam logic [ADDR_W-1:0] VEC_JOYPAD = 16'h0060;

  localparam logic [DELAY_W-1:0] DELAY_RST = 2'd2;

  // Sequencer flags.
  typedef struct packed {
    logic               ime;
    logic [DELAY_W-1:0] cnt;
    logic               halted;
    logic               bug;
  } state_t;

  // One input item as held in the input register.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [REQ_W-1:0]  request_bits;
    logic [REQ_W-1:0]  enable_bits;
    logic [ADDR_W-1:0] cur_pc;
    logic [ADDR_W-1:0] cur_sp;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] next_pc;
    logic [ADDR_W-1:0] next_sp;
    logic [BYTE_W-1:0] pushed_high;
    logic [BYTE_W-1:0] pushed_low;
    logic [REQ_W-1:0]  request_after;
    logic              hold_pc_on_fetch;
    logic [CYC_W-1:0]  cycle_cost;
    logic              master_enable;
  } result_t;

  // Vector address of a source number.
  function automatic logic [ADDR_W-1:0] vector_of(input logic [SRC_W-1:0] src);
    logic [ADDR_W-1:0] v;
    unique case (src)
      3'd0:    v = VEC_VBLANK;
      3'd1:    v = VEC_STAT;
      3'd2:    v = VEC_TIMER;
      3'd3:    v = VEC_SERIAL;
      default: v = VEC_JOYPAD;
    endcase
    return v;
  endfunction

endpackage

>>> sv/idhc_in_if.sv
interface idhc_in_if;
  logic                          valid;
  logic                          ready;
  logic [idhc_pkg::MODE_W-1:0]   mode;
  logic [idhc_pkg::REQ_W-1:0]    request_bits;
  logic [idhc_pkg::REQ_W-1:0]    enable_bits;
  logic [idhc_pkg::ADDR_W-1:0]   cur_pc;
  logic [idhc_pkg::ADDR_W-1:0]   cur_sp;

  modport source (output valid, mode, request_bits, enable_bits, cur_pc, cur_sp,
                  input ready);
  modport sink (input valid, mode, request_bits, enable_bits, cur_pc, cur_sp,
                output ready);
endinterface

>>> sv/idhc_out_if.sv
interface idhc_out_if;
  logic                          valid;
  logic                          ready;
  logic [idhc_pkg::ACT_W-1:0]    action;
  logic [idhc_pkg::ADDR_W-1:0]   next_pc;
  logic [idhc_pkg::ADDR_W-1:0]   next_sp;
  logic [idhc_pkg::BYTE_W-1:0]   pushed_high;
  logic [idhc_pkg::BYTE_W-1:0]   pushed_low;
  logic [idhc_pkg::REQ_W-1:0]    request_after;
  logic                          hold_pc_on_fetch;
  logic [idhc_pkg::CYC_W-1:0]    cycle_cost;
  logic                          master_enable;

  modport source (output valid, action, next_pc, next_sp, pushed_high, pushed_low,
                  request_after, hold_pc_on_fetch, cycle_cost, master_enable,
                  input ready);
  modport sink (input valid, action, next_pc, next_sp, pushed_high, pushed_low,
                request_after, hold_pc_on_fetch, cycle_cost, master_enable,
                output ready);
endinterface

>>> sv/idhc_step.sv
module idhc_step (
  input  idhc_pkg::state_t                st,
  input  logic [idhc_pkg::DELAY_W-1:0]    delay,
  input  idhc_pkg::item_t                 item,
  output idhc_pkg::result_t               res,
  output idhc_pkg::state_t                st_nxt
);

  logic [idhc_pkg::REQ_W-1:0] pending;
  logic [idhc_pkg::SRC_W-1:0] src;
  logic                       dispatch;

  assign pending = item.request_bits & item.enable_bits;

  // Lowest pending source has priority.
  always_comb begin
    priority if (pending[0]) begin
      src = 3'd0;
    end else if (pending[1]) begin
      src = 3'd1;
    end else if (pending[2]) begin
      src = 3'd2;
    end else if (pending[3]) begin
      src = 3'd3;
    end else begin
      src = 3'd4;
    end
  end

  // Step decision, flag update and delayed-enable tick.
  always_comb begin
    logic [idhc_pkg::DELAY_W-1:0] cnt_dec;

    st_nxt   = st;
    dispatch = 1'b0;
    cnt_dec  = st.cnt - 2'd1;

    res.action           = idhc_pkg::ACT_CONTROL;
    res.next_pc          = item.cur_pc;
    res.next_sp          = item.cur_sp;
    res.pushed_high      = '0;
    res.pushed_low       = '0;
    res.request_after    = item.request_bits;
    res.hold_pc_on_fetch = 1'b0;
    res.cycle_cost       = idhc_pkg::CYC_NONE;

    unique case (item.mode)
      idhc_pkg::MODE_STEP: begin
        if (st.halted) begin
          if (pending == '0) begin
            res.action     = idhc_pkg::ACT_HALT_WAIT;
            res.cycle_cost = idhc_pkg::CYC_HALT_WAIT;
          end else begin
            st_nxt.halted = 1'b0;
            if (st.ime) begin
              dispatch = 1'b1;
            end else begin
              res.action = idhc_pkg::ACT_HALT_WAKE;
            end
          end
        end else if (!st.bug && st.ime && pending != '0) begin
          dispatch = 1'b1;
        end else begin
          res.action = idhc_pkg::ACT_FETCH;
          if (st.bug) begin
            res.hold_pc_on_fetch = 1'b1;
            st_nxt.bug           = 1'b0;
          end
        end

        if (dispatch) begin
          st_nxt.ime        = 1'b0;
          res.request_after = item.request_bits & ~(5'd1 << src);
          res.pushed_high   = item.cur_pc[15:8];
          res.pushed_low    = item.cur_pc[7:0];
          res.next_sp       = item.cur_sp - 16'd2;
          res.next_pc       = idhc_pkg::vector_of(src);
          res.action        = idhc_pkg::ACT_DISPATCH;
          res.cycle_cost    = idhc_pkg::CYC_DISPATCH;
        end

        // The enable countdown ticks after every step.
        if (st.cnt != '0) begin
          st_nxt.cnt = cnt_dec;
          if (cnt_dec == '0) begin
            st_nxt.ime = 1'b1;
          end
        end
      end
      idhc_pkg::MODE_HALT: begin
        st_nxt.halted = 1'b1;
      end
      idhc_pkg::MODE_ENABLE: begin
        st_nxt.cnt = (delay == '0) ? 2'd1 : delay;
      end
      idhc_pkg::MODE_DISABLE: begin
        st_nxt.ime = 1'b0;
        st_nxt.cnt = '0;
      end
      idhc_pkg::MODE_BUG: begin
        st_nxt.bug = 1'b1;
      end
      default: begin
        st_nxt = st;
      end
    endcase

    res.master_enable = st_nxt.ime;
  end

endmodule

>>> sv/interrupt_dispatch_halt_control_top.sv
// Channel  Direction  Handshake            Payload
// in_ch    in         valid / ready        mode, request_bits, enable_bits, cur_pc, cur_sp
// out_ch   out        valid / ready        action, next_pc, next_sp, pushed bytes,
//                                          request_after, hold_pc_on_fetch, cycle_cost,
//                                          master_enable
// cfg      in         cfg_we, no ready     cfg_wdata = enable_delay_steps
//
// One item per cycle is sustained while out_ch.ready stays high; an item moves from the input
// register into the result register, where its result is offered on out_ch.
// Reset is synchronous on rst_n low: master enable set, countdown, halted and halt bug
// cleared, enable delay back to 2.
// A stalled result holds in the result register; the input register keeps taking
// items as long as the result register is empty or frees up in the same cycle.
module interrupt_dispatch_halt_control_top (
  input  logic                           clk,
  input  logic                           rst_n,
  idhc_in_if.sink                        in_ch,
  idhc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [idhc_pkg::DELAY_W-1:0]   cfg_wdata
);

  logic [idhc_pkg::DELAY_W-1:0] delay_r;
  idhc_pkg::state_t             st_r;
  idhc_pkg::state_t             st_nxt;
  logic                         s1_valid_r;
  idhc_pkg::item_t              s1_item_r;
  logic                         out_valid_r;
  idhc_pkg::result_t            out_res_r;
  idhc_pkg::result_t            res;
  logic                         s1_adv;
  logic                         in_xfer;

  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer = in_ch.valid && in_ch.ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= idhc_pkg::DELAY_RST;
    end else if (cfg_we) begin
      delay_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.mode         <= in_ch.mode;
      s1_item_r.request_bits <= in_ch.request_bits;
      s1_item_r.enable_bits  <= in_ch.enable_bits;
      s1_item_r.cur_pc       <= in_ch.cur_pc;
      s1_item_r.cur_sp       <= in_ch.cur_sp;
    end
  end

  // Step decision.
  idhc_step u_step (
    .st     (st_r),
    .delay  (delay_r),
    .item   (s1_item_r),
    .res    (res),
    .st_nxt (st_nxt)
  );

  // Flags advance when the item moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.ime    <= 1'b1;
      st_r.cnt    <= '0;
      st_r.halted <= 1'b0;
      st_r.bug    <= 1'b0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.action           = out_res_r.action;
  assign out_ch.next_pc          = out_res_r.next_pc;
  assign out_ch.next_sp          = out_res_r.next_sp;
  assign out_ch.pushed_high      = out_res_r.pushed_high;
  assign out_ch.pushed_low       = out_res_r.pushed_low;
  assign out_ch.request_after    = out_res_r.request_after;
  assign out_ch.hold_pc_on_fetch = out_res_r.hold_pc_on_fetch;
  assign out_ch.cycle_cost       = out_res_r.cycle_cost;
  assign out_ch.master_enable    = out_res_r.master_enable;

endmodule

>>> sv/idhc_checker.sv
module idhc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [idhc_pkg::ACT_W-1:0]    action,
  input logic [idhc_pkg::ADDR_W-1:0]   next_pc,
  input logic [idhc_pkg::BYTE_W-1:0]   pushed_high,
  input logic [idhc_pkg::BYTE_W-1:0]   pushed_low,
  input logic                          hold_pc_on_fetch,
  input logic [idhc_pkg::CYC_W-1:0]    cycle_cost
);

  // A dispatch jumps to one of the vectors and costs the full dispatch time.
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && action == idhc_pkg::ACT_DISPATCH |->
      cycle_cost == idhc_pkg::CYC_DISPATCH &&
      (next_pc == idhc_pkg::VEC_VBLANK || next_pc == idhc_pkg::VEC_STAT ||
       next_pc == idhc_pkg::VEC_TIMER || next_pc == idhc_pkg::VEC_SERIAL ||
       next_pc == idhc_pkg::VEC_JOYPAD))
    else $error("dispatch result with wrong vector or cost");

  // Without a dispatch nothing is pushed, and the halt wait cost shows exactly on a halt wait.
  a_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && action != idhc_pkg::ACT_DISPATCH |->
      pushed_high == '0 && pushed_low == '0 &&
      ((action == idhc_pkg::ACT_HALT_WAIT) == (cycle_cost == idhc_pkg::CYC_HALT_WAIT)))
    else $error("non-dispatch result with push bytes or wrong cost");

  // The halt bug only ever shows on a fetch.
  a_bug_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hold_pc_on_fetch |-> action == idhc_pkg::ACT_FETCH)
    else $error("held PC outside a fetch");

  // A stalled result stays valid and keeps its action and next_pc.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(next_pc))
    else $error("stalled result changed");

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind interrupt_dispatch_halt_control_top idhc_checker u_idhc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .action           (out_ch.action),
  .next_pc          (out_ch.next_pc),
  .pushed_high      (out_ch.pushed_high),
  .pushed_low       (out_ch.pushed_low),
  .hold_pc_on_fetch (out_ch.hold_pc_on_fetch),
  .cycle_cost       (out_ch.cycle_cost)
);
